FILE: hw/rtl/hsv2rgb_pkg.sv
// Shared types and fixed constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  // Input item: hue in degrees, saturation and brightness in percent
  typedef struct packed {
    logic [15:0] hue;
    logic [6:0]  saturation;
    logic [6:0]  brightness;
  } hsv_t;

  // Result item: one 8-bit intensity per channel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Six 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP  = 3'd0,
    SEC_RED_DOWN      = 3'd1,
    SEC_GREEN_BLUE_UP = 3'd2,
    SEC_GREEN_DOWN    = 3'd3,
    SEC_BLUE_RED_UP   = 3'd4,
    SEC_BLUE_DOWN     = 3'd5
  } sector_t;

  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [8:0]  HUE_TURN    = 9'd360;
  localparam logic [5:0]  SECTOR_SPAN = 6'd60;

  // Reciprocals for division by a constant: floor(x / d) = (x * R) >> S
  // floor(2^24 / 360); quotient may come out one low, corrected afterward
  localparam logic [15:0] HUE_RECIP   = 16'd46603;
  // ceil(2^19 / 100); exact for x <= 25500
  localparam logic [12:0] PCT_RECIP   = 13'd5243;
  // ceil(2^16 / 60); exact for x < 360
  localparam logic [10:0] SEC_RECIP   = 11'd1093;
  // ceil(2^20 / 60); exact for x <= 255 * 59
  localparam logic [14:0] RAMP_RECIP  = 15'd17477;

endpackage

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter: seven-stage pipeline, one item per clock.
//
//   channel | signals             | direction | notes
//   --------+---------------------+-----------+--------------------------------
//   input   | start, busy, pixel  | in        | taken when start && !busy
//   result  | done, color         | out       | color valid for the cycle of done
//
// Throughput is one item per clock; busy stays low since nothing inside stalls.
// The pipeline is six arithmetic stages, five of them built around a
// constant-reciprocal multiply, each closed by a register, then the output register.
// Reset clears the valid bits of every stage; items in flight are dropped.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire hsv_t pixel,
  output logic      done,
  output rgb_t      color
);

  // Stage valid bits
  logic v1, v2, v3, v4, v5, v6, v7;

  // Stage 1 registers
  logic [15:0] hue1;
  logic [7:0]  quot1;
  logic [14:0] v255_1;
  logic [6:0]  sat1;
  // Stage 2 registers
  logic [8:0]  h2;
  logic [7:0]  peak2;
  logic [6:0]  sat2;
  // Stage 3 registers
  logic [8:0]  h3;
  logic [2:0]  sector3;
  logic [7:0]  peak3;
  logic [14:0] base_prod3;
  // Stage 4 registers
  sector_t     sector4;
  logic [5:0]  frac4;
  logic [7:0]  peak4;
  logic [7:0]  base4;
  // Stage 5 registers
  sector_t     sector5;
  logic [13:0] ramp_prod5;
  logic [7:0]  peak5;
  logic [7:0]  base5;
  // Stage 6 registers
  sector_t     sector6;
  logic [7:0]  ramp6;
  logic [7:0]  peak6;
  logic [7:0]  base6;

  // Combinational terms
  logic [6:0]  sat_clamp, bri_clamp;
  logic [31:0] hue_prod;
  logic [16:0] hue_rem;
  logic [27:0] peak_prod;
  logic [19:0] sec_prod;
  logic [8:0]  sec_start;
  logic [8:0]  frac_wide;
  logic [27:0] base_prod;
  logic [7:0]  diff5;
  logic [28:0] ramp_full;
  logic [7:0]  up6, down6;
  rgb_t        color_next;

  // Never stalls
  assign busy = 1'b0;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Stage 1: clamp percents, estimate hue / 360, form brightness * 255
  assign sat_clamp = (pixel.saturation > PCT_FULL) ? PCT_FULL : pixel.saturation;
  assign bri_clamp = (pixel.brightness > PCT_FULL) ? PCT_FULL : pixel.brightness;
  assign hue_prod  = {16'd0, pixel.hue} * {16'd0, HUE_RECIP};

  always_ff @(posedge clk) begin
    hue1   <= pixel.hue;
    quot1  <= hue_prod[31:24];
    v255_1 <= {bri_clamp, 8'd0} - {8'd0, bri_clamp};
    sat1   <= sat_clamp;
  end

  // Stage 2: finish hue mod 360, peak = floor(v * 255 / 100)
  assign hue_rem   = {1'b0, hue1} - ({9'd0, quot1} * {8'd0, HUE_TURN});
  assign peak_prod = {13'd0, v255_1} * {15'd0, PCT_RECIP};

  always_ff @(posedge clk) begin
    h2    <= (hue_rem >= {8'd0, HUE_TURN}) ? 9'(hue_rem - {8'd0, HUE_TURN})
                                           : hue_rem[8:0];
    peak2 <= peak_prod[26:19];
    sat2  <= sat1;
  end

  // Stage 3: sector = h / 60, start the floor product
  assign sec_prod = {11'd0, h2} * {9'd0, SEC_RECIP};

  always_ff @(posedge clk) begin
    h3         <= h2;
    sector3    <= sec_prod[18:16];
    peak3      <= peak2;
    base_prod3 <= {7'd0, peak2} * {8'd0, 7'(PCT_FULL - sat2)};
  end

  // Stage 4: position inside the sector, floor = base_prod / 100
  assign sec_start = {6'd0, sector3} * {3'd0, SECTOR_SPAN};
  assign frac_wide = h3 - sec_start;
  assign base_prod = {13'd0, base_prod3} * {15'd0, PCT_RECIP};

  always_ff @(posedge clk) begin
    sector4 <= sector_t'(sector3);
    frac4   <= frac_wide[5:0];
    peak4   <= peak3;
    base4   <= base_prod[26:19];
  end

  // Stage 5: span times position
  assign diff5 = peak4 - base4;

  always_ff @(posedge clk) begin
    sector5    <= sector4;
    ramp_prod5 <= {6'd0, diff5} * {8'd0, frac4};
    peak5      <= peak4;
    base5      <= base4;
  end

  // Stage 6: ramp = ramp_prod / 60
  assign ramp_full = {15'd0, ramp_prod5} * {14'd0, RAMP_RECIP};

  always_ff @(posedge clk) begin
    sector6 <= sector5;
    ramp6   <= ramp_full[27:20];
    peak6   <= peak5;
    base6   <= base5;
  end

  // Stage 7: pick the channel roles for the sector
  assign up6   = base6 + ramp6;
  assign down6 = peak6 - ramp6;

  always_comb begin
    unique case (sector6)
      SEC_RED_GREEN_UP:  color_next = '{red: peak6, green: up6,   blue: base6};
      SEC_RED_DOWN:      color_next = '{red: down6, green: peak6, blue: base6};
      SEC_GREEN_BLUE_UP: color_next = '{red: base6, green: peak6, blue: up6};
      SEC_GREEN_DOWN:    color_next = '{red: base6, green: down6, blue: peak6};
      SEC_BLUE_RED_UP:   color_next = '{red: up6,   green: base6, blue: peak6};
      SEC_BLUE_DOWN:     color_next = '{red: peak6, green: base6, blue: down6};
      default:           color_next = '{red: peak6, green: base6, blue: down6};
    endcase
  end

  always_ff @(posedge clk) begin
    color <= color_next;
  end

  assign done = v7;

  // A result only follows an item accepted earlier
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 7))
    else $error("result without a matching item");

  // Reduced hue stays inside one turn and its sector index stays at most five
  a_hue_reduced: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (h3 < HUE_TURN) && (sector3 <= 3'd5))
    else $error("hue reduction out of range");

  // Position inside a sector stays below its span
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (frac4 < SECTOR_SPAN))
    else $error("sector position out of range");

  // Floor never exceeds peak
  a_base_le_peak: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (base4 <= peak4))
    else $error("floor level above peak");

  // Ramp never spans more than peak minus floor
  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    v6 |-> ({1'b0, ramp6} + {1'b0, base6} <= {1'b0, peak6}))
    else $error("ramp exceeds level span");

endmodule

`default_nettype wire
